>>> sv/cicy_pkg.sv
package cicy_pkg;

  // Parameter defaults
  localparam int SIZE_BITS_DEF    = 32;
  localparam int METAINT_BITS_DEF = 24;

  // Fixed sizes
  localparam int META_BLOCK_UNIT = 16;
  localparam int UNIT_SHIFT      = $clog2(META_BLOCK_UNIT);
  localparam int META_REM_W      = 8 + UNIT_SHIFT;
  localparam int METAINT_REG_W   = 24;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = METAINT_REG_W;
  localparam logic [METAINT_REG_W-1:0] METAINT_RESET = 24'd8192;

  // Queue depths
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CHUNKED_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ICY_ENABLE     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ICY_METAINT    = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_AUDIO     = 3'd0;
  localparam logic [2:0] KIND_META      = 3'd1;
  localparam logic [2:0] KIND_META_END  = 3'd2;
  localparam logic [2:0] KIND_STREAM_END = 3'd3;
  localparam logic [2:0] KIND_ERROR     = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR  = 3'd1;
  localparam logic [2:0] ERR_NO_LF     = 3'd2;
  localparam logic [2:0] ERR_NO_CR     = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

  // Framing characters
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_buffer;
  } in_word_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_out;
    logic       meta_last;
    logic [2:0] error_code;
    logic       group_end;
  } out_word_t;

  // What the framing parser hands to the demuxer
  typedef enum logic [1:0] {
    OP_DEMUX,
    OP_END,
    OP_ERR
  } cicy_op_t;

  typedef struct packed {
    cicy_op_t   op;
    logic [7:0] data_byte;
    logic [2:0] error_code;
    logic       group_end;
  } mid_word_t;

  typedef struct packed {
    logic                     icy_enable;
    logic [METAINT_REG_W-1:0] metaint;
    logic                     restart;
  } icy_cfg_t;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_EXT,
    PH_SIZE_LF,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF
  } chunk_phase_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_END,
    ST_ERR
  } stream_status_t;

  typedef enum logic [1:0] {
    DM_AUDIO,
    DM_LEN,
    DM_META
  } demux_phase_t;

  // {valid, value} of an ASCII hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

>>> sv/cicy_fifo.sv
module cicy_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> sv/cicy_front.sv
module cicy_front #(
  parameter int SIZE_BITS = cicy_pkg::SIZE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                chunked_enable,
  input  logic                push,
  input  cicy_pkg::in_word_t  item,
  output logic                full,
  output logic                mid_push,
  output cicy_pkg::mid_word_t mid_word,
  input  logic                mid_full
);
  import cicy_pkg::*;

  chunk_phase_t         phase, phase_next;
  logic [SIZE_BITS-1:0] remaining, remaining_next;
  stream_status_t       status, status_next;
  logic [2:0]           saved_error, saved_error_next;

  logic       accept;
  logic       emit;
  logic [7:0] b;
  logic       is_cr, is_lf, is_semi;
  logic [4:0] hex;
  logic       top_nz;
  logic       rem_zero;
  logic       running;

  assign accept   = push && !mid_full;
  assign full     = mid_full;
  assign b        = item.data_byte;
  assign is_cr    = (b == CHAR_CR);
  assign is_lf    = (b == CHAR_LF);
  assign is_semi  = (b == CHAR_SEMI);
  assign hex      = hex_decode(b);
  assign top_nz   = |remaining[SIZE_BITS-1:SIZE_BITS-4];
  assign rem_zero = (remaining == '0);
  assign running  = (status == ST_RUN) && chunked_enable;

  // next phase
  always_comb begin
    phase_next = phase;
    if (running) begin
      case (phase)
        PH_SIZE: begin
          if (is_cr) begin
            phase_next = PH_SIZE_LF;
          end else if (is_semi) begin
            phase_next = PH_EXT;
          end
        end
        PH_EXT: begin
          if (is_cr) begin
            phase_next = PH_SIZE_LF;
          end
        end
        PH_SIZE_LF: begin
          if (is_lf) begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          if (!rem_zero && remaining == SIZE_BITS'(1)) begin
            phase_next = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (is_cr) begin
            phase_next = PH_DATA_LF;
          end
        end
        PH_DATA_LF: begin
          if (is_lf) begin
            phase_next = PH_SIZE;
          end
        end
        default: phase_next = PH_SIZE;
      endcase
    end
  end

  // words handed on, counter and sticky status
  always_comb begin
    emit               = 1'b0;
    mid_word.op        = OP_DEMUX;
    mid_word.data_byte = b;
    mid_word.error_code = ERR_NONE;
    mid_word.group_end = item.last_in_buffer;
    remaining_next     = remaining;
    status_next        = status;
    saved_error_next   = saved_error;
    if (status == ST_ERR) begin
      emit                = 1'b1;
      mid_word.op         = OP_ERR;
      mid_word.error_code = saved_error;
    end else if (status == ST_END) begin
      emit        = 1'b1;
      mid_word.op = OP_END;
    end else if (!chunked_enable) begin
      emit = 1'b1;
    end else begin
      case (phase)
        PH_SIZE: begin
          if (!is_cr && !is_semi) begin
            if (!hex[4]) begin
              emit                = 1'b1;
              mid_word.op         = OP_ERR;
              mid_word.error_code = ERR_BAD_CHAR;
            end else if (top_nz) begin
              emit                = 1'b1;
              mid_word.op         = OP_ERR;
              mid_word.error_code = ERR_OVERFLOW;
            end else begin
              remaining_next = {remaining[SIZE_BITS-5:0], hex[3:0]};
            end
          end
        end
        PH_SIZE_LF, PH_DATA_LF: begin
          if (!is_lf) begin
            emit                = 1'b1;
            mid_word.op         = OP_ERR;
            mid_word.error_code = ERR_NO_LF;
          end
        end
        PH_DATA: begin
          emit = 1'b1;
          if (rem_zero) begin
            mid_word.op = OP_END;
            status_next = ST_END;
          end else begin
            remaining_next = remaining - SIZE_BITS'(1);
          end
        end
        PH_DATA_CR: begin
          if (!is_cr) begin
            emit                = 1'b1;
            mid_word.op         = OP_ERR;
            mid_word.error_code = ERR_NO_CR;
          end
        end
        default: emit = 1'b0;
      endcase
      if (mid_word.op == OP_ERR) begin
        status_next      = ST_ERR;
        saved_error_next = mid_word.error_code;
      end
    end
  end

  assign mid_push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SIZE;
      remaining   <= '0;
      status      <= ST_RUN;
      saved_error <= ERR_NONE;
    end else if (accept) begin
      phase       <= phase_next;
      remaining   <= remaining_next;
      status      <= status_next;
      saved_error <= saved_error_next;
    end
  end

endmodule

>>> sv/cicy_back.sv
module cicy_back #(
  parameter int METAINT_BITS = cicy_pkg::METAINT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cicy_pkg::icy_cfg_t  cfg,
  input  logic                mid_empty,
  input  cicy_pkg::mid_word_t mid_word,
  output logic                mid_pop,
  input  logic                out_full,
  output logic                out_push,
  output cicy_pkg::out_word_t out_word
);
  import cicy_pkg::*;

  demux_phase_t            phase, phase_next;
  logic [METAINT_BITS-1:0] audio_rem, audio_rem_next;
  logic [META_REM_W-1:0]   meta_rem, meta_rem_next;

  logic                    take;
  logic                    emit;
  logic [7:0]              b;
  logic [METAINT_BITS-1:0] audio_dec;
  logic [META_REM_W-1:0]   meta_dec;
  logic                    closes;
  logic                    demuxing;

  function automatic logic [METAINT_BITS-1:0] metaint_load(
    input logic [METAINT_REG_W-1:0] m
  );
    logic [METAINT_BITS-1:0] v;
    v = METAINT_BITS'(m);
    return (v == '0) ? METAINT_BITS'(1) : v;
  endfunction

  assign take      = !mid_empty && !out_full;
  assign mid_pop   = take;
  assign b         = mid_word.data_byte;
  assign audio_dec = audio_rem - METAINT_BITS'(1);
  assign meta_dec  = meta_rem - META_REM_W'(1);
  assign closes    = (meta_dec == '0);
  assign demuxing  = (mid_word.op == OP_DEMUX) && cfg.icy_enable;

  // next state
  always_comb begin
    phase_next     = phase;
    audio_rem_next = audio_rem;
    meta_rem_next  = meta_rem;
    if (demuxing) begin
      case (phase)
        DM_AUDIO: begin
          audio_rem_next = audio_dec;
          if (audio_dec == '0) begin
            phase_next = DM_LEN;
          end
        end
        DM_LEN: begin
          if (b == 8'h00) begin
            phase_next     = DM_AUDIO;
            audio_rem_next = metaint_load(cfg.metaint);
          end else begin
            meta_rem_next = {b, UNIT_SHIFT'(0)};
            phase_next    = DM_META;
          end
        end
        DM_META: begin
          meta_rem_next = meta_dec;
          if (closes) begin
            phase_next     = DM_AUDIO;
            audio_rem_next = metaint_load(cfg.metaint);
          end
        end
        default: phase_next = DM_AUDIO;
      endcase
    end
  end

  // result word
  always_comb begin
    emit                = 1'b0;
    out_word.kind       = KIND_AUDIO;
    out_word.data_out   = 8'h00;
    out_word.meta_last  = 1'b0;
    out_word.error_code = ERR_NONE;
    out_word.group_end  = mid_word.group_end;
    case (mid_word.op)
      OP_ERR: begin
        emit                = 1'b1;
        out_word.kind       = KIND_ERROR;
        out_word.error_code = mid_word.error_code;
      end
      OP_END: begin
        emit          = 1'b1;
        out_word.kind = KIND_STREAM_END;
      end
      OP_DEMUX: begin
        if (!cfg.icy_enable || phase == DM_AUDIO) begin
          emit              = 1'b1;
          out_word.data_out = b;
        end else if (phase == DM_META) begin
          if (b != 8'h00) begin
            emit               = 1'b1;
            out_word.kind      = KIND_META;
            out_word.data_out  = b;
            out_word.meta_last = closes;
          end else if (closes) begin
            emit          = 1'b1;
            out_word.kind = KIND_META_END;
          end
        end
      end
      default: emit = 1'b0;
    endcase
  end

  assign out_push = take && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= DM_AUDIO;
      audio_rem <= metaint_load(METAINT_RESET);
      meta_rem  <= '0;
    end else if (cfg.restart) begin
      phase     <= DM_AUDIO;
      audio_rem <= metaint_load(cfg.metaint);
      meta_rem  <= '0;
    end else if (take) begin
      phase     <= phase_next;
      audio_rem <= audio_rem_next;
      meta_rem  <= meta_rem_next;
    end
  end

endmodule

>>> sv/chunked_icy_stream_demuxer_core.sv
// Path: framing is combinational into the middle queue and the demux stage
//   writes the result queue, so a word passes through both queues before it
//   reaches the result ports, where pop takes it.
// Throughput: one input word per cycle, sustained, while pop keeps up; bytes
//   that make no result (framing, length, inner null bytes) still take a slot.
// Reset: rst is synchronous, active high; it empties both queues, returns the
//   parser to size reading, clears sticky status and loads metaint = 8192.
module chunked_icy_stream_demuxer_core #(
  parameter int SIZE_BITS    = cicy_pkg::SIZE_BITS_DEF,
  parameter int METAINT_BITS = cicy_pkg::METAINT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_write,
  input  logic [cicy_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cicy_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input queue side
  input  logic                             push,
  input  cicy_pkg::in_word_t               item,
  output logic                             full,
  // result queue side
  output logic                             empty,
  input  logic                             pop,
  output cicy_pkg::out_word_t              result
);
  import cicy_pkg::*;

  // Configuration registers
  logic                     chunked_enable;
  logic                     icy_enable;
  logic [METAINT_REG_W-1:0] metaint_cfg;
  icy_cfg_t                 icy_cfg;

  // Front -> mid queue -> back
  logic      mid_push, mid_full, mid_pop, mid_empty;
  mid_word_t mid_in, mid_out;

  // Back -> result queue
  logic      out_push, out_full;
  out_word_t out_in;

  // Register writes. A metaint write also restarts the demuxer in audio
  // phase; enable writes touch nothing else. Unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      chunked_enable <= 1'b0;
      icy_enable     <= 1'b0;
      metaint_cfg    <= METAINT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CHUNKED_ENABLE: chunked_enable <= cfg_data[0];
        REG_ICY_ENABLE:     icy_enable     <= cfg_data[0];
        REG_ICY_METAINT:    metaint_cfg    <= cfg_data[METAINT_REG_W-1:0];
        default:            ;
      endcase
    end
  end

  // The restart pulse carries the freshly written value straight through so
  // the demuxer reloads in the same edge as the register.
  assign icy_cfg.icy_enable = icy_enable;
  assign icy_cfg.restart    = cfg_write && (cfg_index == REG_ICY_METAINT);
  assign icy_cfg.metaint    = icy_cfg.restart ? cfg_data[METAINT_REG_W-1:0]
                                              : metaint_cfg;

  // Front: chunked framing parser, sticky end / error. Drops framing bytes,
  // forwards data bytes and status words.
  cicy_front #(
    .SIZE_BITS (SIZE_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .chunked_enable (chunked_enable),
    .push           (push),
    .item           (item),
    .full           (full),
    .mid_push       (mid_push),
    .mid_word       (mid_in),
    .mid_full       (mid_full)
  );

  // Short queue decoupling parser from demuxer
  cicy_fifo #(
    .WIDTH ($bits(mid_word_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_out),
    .empty (mid_empty)
  );

  // Back: ICY audio / metadata split, builds result words
  cicy_back #(
    .METAINT_BITS (METAINT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (icy_cfg),
    .mid_empty (mid_empty),
    .mid_word  (mid_out),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_word  (out_in)
  );

  // Result queue: holds finished words while the consumer stalls
  cicy_fifo #(
    .WIDTH ($bits(out_word_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_in),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

>>> tb/chunked_icy_stream_demuxer_core_checker.sv
`timescale 1ns / 100ps

module chunked_icy_stream_demuxer_core_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [cicy_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cicy_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             push,
  input  cicy_pkg::in_word_t               item,
  input  logic                             full,
  input  logic                             empty,
  input  logic                             pop,
  input  cicy_pkg::out_word_t              result,
  output int                               errors,
  output int                               pending
);
  import cicy_pkg::*;

  // register copies
  logic                        chunked_on;
  logic                        icy_on;
  logic [METAINT_REG_W-1:0]    metaint_reg;

  // framing and demux state
  chunk_phase_t                frame_phase;
  logic [SIZE_BITS_DEF-1:0]    chunk_left;
  stream_status_t              status;
  logic [2:0]                  sticky_code;
  demux_phase_t                dm_phase;
  logic [METAINT_BITS_DEF-1:0] audio_left;
  logic [META_REM_W-1:0]       meta_left;

  out_word_t                   expected_q[$];
  out_word_t                   next_result;

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: MISMATCH %s", $time, msg);
    errors++;
  endtask

  function automatic out_word_t make_word(input logic [2:0] kind, input logic [7:0] data,
                                          input logic last, input logic [2:0] code,
                                          input logic grp);
    out_word_t w;
    w.kind       = kind;
    w.data_out   = data;
    w.meta_last  = last;
    w.error_code = code;
    w.group_end  = grp;
    return w;
  endfunction

  // metaint of zero counts as one
  function automatic logic [METAINT_BITS_DEF-1:0] audio_reload();
    return (metaint_reg == '0) ? METAINT_BITS_DEF'(1) : METAINT_BITS_DEF'(metaint_reg);
  endfunction

  function automatic out_word_t raise_error(input logic [2:0] code, input logic grp);
    status      = ST_ERR;
    sticky_code = code;
    return make_word(KIND_ERROR, 8'h00, 1'b0, code, grp);
  endfunction

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
      return 1'b1;
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h61 + 8'd10);
      return 1'b1;
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h41 + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit demux_byte(input logic [7:0] b, input logic grp,
                                    output out_word_t r);
    logic closes;
    r = '0;
    if (!icy_on) begin
      r = make_word(KIND_AUDIO, b, 1'b0, ERR_NONE, grp);
      return 1'b1;
    end
    case (dm_phase)
      DM_AUDIO: begin
        audio_left = audio_left - 1'b1;
        if (audio_left == '0) dm_phase = DM_LEN;
        r = make_word(KIND_AUDIO, b, 1'b0, ERR_NONE, grp);
        return 1'b1;
      end
      DM_LEN: begin
        if (b == 8'h00) begin
          dm_phase   = DM_AUDIO;
          audio_left = audio_reload();
        end else begin
          meta_left = {b, 4'h0};
          dm_phase  = DM_META;
        end
        return 1'b0;
      end
      default: begin
        meta_left = meta_left - 1'b1;
        closes    = (meta_left == '0);
        if (closes) begin
          dm_phase   = DM_AUDIO;
          audio_left = audio_reload();
        end
        if (b != 8'h00) begin
          r = make_word(KIND_META, b, closes, ERR_NONE, grp);
          return 1'b1;
        end
        if (closes) begin
          r = make_word(KIND_META_END, 8'h00, 1'b0, ERR_NONE, grp);
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // one accepted input word -> zero or one result word
  function automatic bit predict_word(input in_word_t w, output out_word_t r);
    logic [7:0] b;
    logic       g;
    logic [3:0] nib;
    b = w.data_byte;
    g = w.last_in_buffer;
    r = '0;
    if (status == ST_ERR) begin
      r = make_word(KIND_ERROR, 8'h00, 1'b0, sticky_code, g);
      return 1'b1;
    end
    if (status == ST_END) begin
      r = make_word(KIND_STREAM_END, 8'h00, 1'b0, ERR_NONE, g);
      return 1'b1;
    end
    if (!chunked_on) return demux_byte(b, g, r);
    case (frame_phase)
      PH_SIZE: begin
        if (b == CHAR_CR) begin
          frame_phase = PH_SIZE_LF;
          return 1'b0;
        end
        if (b == CHAR_SEMI) begin
          frame_phase = PH_EXT;
          return 1'b0;
        end
        if (!hex_nibble(b, nib)) begin
          r = raise_error(ERR_BAD_CHAR, g);
          return 1'b1;
        end
        if (chunk_left[SIZE_BITS_DEF-1 -: 4] != 4'h0) begin
          r = raise_error(ERR_OVERFLOW, g);
          return 1'b1;
        end
        chunk_left = {chunk_left[SIZE_BITS_DEF-5:0], nib};
        return 1'b0;
      end
      PH_EXT: begin
        if (b == CHAR_CR) frame_phase = PH_SIZE_LF;
        return 1'b0;
      end
      PH_SIZE_LF: begin
        if (b != CHAR_LF) begin
          r = raise_error(ERR_NO_LF, g);
          return 1'b1;
        end
        frame_phase = PH_DATA;
        return 1'b0;
      end
      PH_DATA: begin
        if (chunk_left == '0) begin
          status = ST_END;
          r = make_word(KIND_STREAM_END, 8'h00, 1'b0, ERR_NONE, g);
          return 1'b1;
        end
        chunk_left = chunk_left - 1'b1;
        if (chunk_left == '0) frame_phase = PH_DATA_CR;
        return demux_byte(b, g, r);
      end
      PH_DATA_CR: begin
        if (b != CHAR_CR) begin
          r = raise_error(ERR_NO_CR, g);
          return 1'b1;
        end
        frame_phase = PH_DATA_LF;
        return 1'b0;
      end
      default: begin
        if (b != CHAR_LF) begin
          r = raise_error(ERR_NO_LF, g);
          return 1'b1;
        end
        frame_phase = PH_SIZE;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic apply_config(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_CHUNKED_ENABLE: chunked_on = data[0];
      REG_ICY_ENABLE:     icy_on = data[0];
      REG_ICY_METAINT: begin
        metaint_reg = data[METAINT_REG_W-1:0];
        dm_phase    = DM_AUDIO;
        audio_left  = audio_reload();
        meta_left   = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: kind %0d data %02h",
                                got.kind, got.data_out));
      return;
    end
    want = expected_q.pop_front();
    if (got.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
    if (got.data_out !== want.data_out)
      report_mismatch($sformatf("data_out %02h, expected %02h", got.data_out, want.data_out));
    if (got.meta_last !== want.meta_last)
      report_mismatch($sformatf("meta_last %0b, expected %0b", got.meta_last, want.meta_last));
    if (got.error_code !== want.error_code)
      report_mismatch($sformatf("error_code %0d, expected %0d", got.error_code,
                                want.error_code));
    if (got.group_end !== want.group_end)
      report_mismatch($sformatf("group_end %0b, expected %0b", got.group_end, want.group_end));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      chunked_on  = 1'b0;
      icy_on      = 1'b0;
      metaint_reg = METAINT_RESET;
      frame_phase = PH_SIZE;
      chunk_left  = '0;
      status      = ST_RUN;
      sticky_code = ERR_NONE;
      dm_phase    = DM_AUDIO;
      audio_left  = audio_reload();
      meta_left   = '0;
      expected_q.delete();
    end else begin
      if (pop && !empty) check_word(result);
      if (cfg_write) apply_config(cfg_index, cfg_data);
      if (push && !full) begin
        if (predict_word(item, next_result)) expected_q.push_back(next_result);
      end
    end
    pending <= expected_q.size();
  end

endmodule

>>> tb/chunked_icy_stream_demuxer_core_tb.sv
`timescale 1ns / 100ps

module chunked_icy_stream_demuxer_core_tb;
  import cicy_pkg::*;

  localparam int SEGMENTS       = 10;
  localparam int SEG_WORDS      = 125;   // ~1250 random words over all segments
  localparam int HOLD_CYCLES    = 400;   // long receiver stall, fills both queues
  localparam int SETTLE_CYCLES  = 20;    // words with no result may still be in flight
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving on either side
  // spare index, past the last register; writes must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   push      = 1'b0;
  in_word_t               item      = '0;
  logic                   full;
  logic                   empty;
  logic                   pop       = 1'b0;
  out_word_t              result;

  int  fail_count;
  int  pending_words;
  int  words_sent  = 0;
  int  tx_idle_pct = 20;
  int  rx_idle_pct = 80;
  int  idle_cycles = 0;
  logic hold_rx    = 1'b0;

  // what the stimulus side believes the registers hold; drives the payload
  // generator so that ICY framing in the stream is mostly well formed
  logic                     cur_chunked = 1'b0;
  logic                     cur_icy     = 1'b0;
  logic [METAINT_REG_W-1:0] cur_metaint = METAINT_RESET;
  demux_phase_t             pl_phase    = DM_AUDIO;
  int                       pl_left     = 8192;

  chunked_icy_stream_demuxer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  chunked_icy_stream_demuxer_core_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .errors    (fail_count),
    .pending   (pending_words)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a run that stops moving words for too long has hung.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random pop, plus one long hold-off on request. The hold-off is
  // timed here, not by the sender, so the sender keeps offering words.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        hold_rx = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic buffer_end();
    return ($urandom_range(7) == 0);
  endfunction

  // ASCII hex digit, letters in random case
  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'(8'h30 + v);
    if ($urandom_range(1)) return 8'(8'h41 + v - 10);
    return 8'(8'h61 + v - 10);
  endfunction

  function automatic int audio_count();
    return (cur_metaint == '0) ? 1 : int'(cur_metaint);
  endfunction

  // Next byte of the demuxer's input stream. With ICY on it follows the
  // audio / length / metadata layout for the current metaint.
  function automatic logic [7:0] next_payload();
    int r;
    int len;
    if (!cur_icy) return 8'($urandom);
    case (pl_phase)
      DM_AUDIO: begin
        pl_left--;
        if (pl_left == 0) pl_phase = DM_LEN;
        return 8'($urandom);
      end
      DM_LEN: begin
        // mostly short blocks, now and then a long one up to 4080 bytes
        r = $urandom_range(99);
        if (r < 30)      len = 0;
        else if (r < 95) len = $urandom_range(1, 3);
        else if (r < 99) len = $urandom_range(4, 15);
        else             len = $urandom_range(16, 255);
        if (len == 0) begin
          pl_phase = DM_AUDIO;
          pl_left  = audio_count();
        end else begin
          pl_phase = DM_META;
          pl_left  = len * 16;
        end
        return 8'(len);
      end
      default: begin
        pl_left--;
        if (pl_left == 0) begin
          // closing byte: null half the time, so both block-end forms occur
          pl_phase = DM_AUDIO;
          pl_left  = audio_count();
          return $urandom_range(1) ? 8'h00 : 8'($urandom_range(1, 255));
        end
        return ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom);
      end
    endcase
  endfunction

  function automatic int chunk_size();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(1, 24);
    return $urandom_range(25, 300);
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= '{data_byte: b, last_in_buffer: lst};
    do @(posedge clk); while (full);
    words_sent++;
  endtask

  // One well-formed chunk: size (leading zeros sometimes), optional
  // extension, CR LF, payload, CR LF.
  task automatic send_chunk(input int n);
    int digits;
    logic [7:0] c;
    digits = 1;
    while (digits < 8 && (n >> (4 * digits)) != 0) digits++;
    if ($urandom_range(5) == 0) repeat ($urandom_range(1, 8 - digits)) send_word(8'h30, buffer_end());
    for (int k = digits - 1; k >= 0; k--) send_word(hex_char((n >> (4 * k)) & 15), buffer_end());
    if ($urandom_range(3) == 0) begin
      send_word(CHAR_SEMI, buffer_end());
      repeat ($urandom_range(4)) begin
        c = 8'($urandom);
        if (c == CHAR_CR) c = CHAR_LF;
        send_word(c, buffer_end());
      end
    end
    send_word(CHAR_CR, buffer_end());
    send_word(CHAR_LF, buffer_end());
    repeat (n) send_word(next_payload(), buffer_end());
    send_word(CHAR_CR, buffer_end());
    send_word(CHAR_LF, buffer_end());
  endtask

  // Stop offering, wait for every expected word, then let words that make
  // no result clear the pipeline (two stages plus the middle queue).
  task automatic drain_and_settle();
    push <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the spare index first, then all three registers. Enable writes
  // carry random upper bits, only bit 0 counts.
  task automatic set_config(input logic ch, input logic icy, input logic [METAINT_REG_W-1:0] mi);
    cfg_write <= 1'b1;
    cfg_index <= REG_SPARE;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_index <= REG_CHUNKED_ENABLE;
    cfg_data  <= {(CFG_DATA_W - 1)'($urandom), ch};
    @(posedge clk);
    cfg_index <= REG_ICY_ENABLE;
    cfg_data  <= {(CFG_DATA_W - 1)'($urandom), icy};
    @(posedge clk);
    cfg_index <= REG_ICY_METAINT;
    cfg_data  <= CFG_DATA_W'(mi);
    @(posedge clk);
    cfg_write   <= 1'b0;
    cur_chunked = ch;
    cur_icy     = icy;
    cur_metaint = mi;
    pl_phase    = DM_AUDIO;
    pl_left     = audio_count();
  endtask

  initial begin
    int seg_start;
    logic [7:0] c;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: both enables off, every byte comes back as audio.
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(CHAR_CR, 1'b1);

    // ICY with the smallest metaint: audio, zero length byte, audio, one
    // 16-byte block with null inner bytes and a non-null closing byte.
    drain_and_settle();
    set_config(1'b0, 1'b1, 24'd1);
    send_word(8'hA5, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(8'h5A, 1'b0);
    send_word(8'h01, 1'b0);
    for (int k = 0; k < 16; k++)
      send_word((k == 1) ? 8'h41 : ((k == 15) ? 8'hFF : 8'h00), k[0]);
    send_word(8'h7E, 1'b1);

    // Random segments, one register setting each. Idling: sender light and
    // receiver heavy, then swapped, then none.
    for (int s = 0; s < SEGMENTS; s++) begin
      drain_and_settle();
      if (s == 3) begin
        tx_idle_pct = 80;
        rx_idle_pct = 20;
      end
      if (s == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (s)
        0:       set_config(1'b0, 1'b1, 24'($urandom_range(1, 32)));
        1:       set_config(1'b1, 1'b1, 24'd1);
        2:       set_config(1'b1, 1'b0, 24'($urandom));
        3:       set_config(1'b0, 1'b1, 24'hFFFFFF);
        4:       set_config(1'b1, 1'b1, 24'd0);  // zero metaint behaves as one
        5:       set_config(1'b0, 1'b0, 24'($urandom));
        6:       set_config(1'b1, 1'b1, 24'($urandom_range(2, 64)));
        7:       set_config(1'b0, 1'b1, 24'($urandom_range(1, 16)));
        8:       set_config(1'b1, 1'b1, 24'($urandom_range(1, 200)));
        default: set_config(1'b1, 1'b1, 24'($urandom_range(1, 32)));
      endcase
      // full-rate sender against a stalled receiver: queues fill, full rises
      if (s == 6) hold_rx = 1'b1;
      seg_start = words_sent;
      while (words_sent - seg_start < SEG_WORDS) begin
        if (cur_chunked) send_chunk(chunk_size());
        else send_word(next_payload(), buffer_end());
      end
    end

    // Stream termination. Error and end are sticky until reset, so only one
    // of them can be reached per run; the seed picks which.
    drain_and_settle();
    set_config(1'b1, 1'($urandom_range(1)), 24'($urandom_range(1, 40)));
    send_chunk(chunk_size());
    send_chunk(chunk_size());
    case ($urandom_range(5))
      0: begin
        // bad size character: not hex, not CR, not ';'
        do c = 8'($urandom);
        while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66) || c == CHAR_CR || c == CHAR_SEMI);
        send_word(c, buffer_end());
      end
      1: begin
        // CR after the size not followed by LF
        send_word(hex_char(1), buffer_end());
        send_word(CHAR_CR, buffer_end());
        c = 8'($urandom);
        if (c == CHAR_LF) c = 8'h00;
        send_word(c, buffer_end());
      end
      2: begin
        // data not followed by CR
        send_word(hex_char(1), buffer_end());
        send_word(CHAR_CR, buffer_end());
        send_word(CHAR_LF, buffer_end());
        send_word(next_payload(), buffer_end());
        c = 8'($urandom);
        if (c == CHAR_CR) c = 8'hFF;
        send_word(c, buffer_end());
      end
      3: begin
        // CR after data not followed by LF
        send_word(hex_char(1), buffer_end());
        send_word(CHAR_CR, buffer_end());
        send_word(CHAR_LF, buffer_end());
        send_word(next_payload(), buffer_end());
        send_word(CHAR_CR, buffer_end());
        c = 8'($urandom);
        if (c == CHAR_LF) c = 8'h00;
        send_word(c, buffer_end());
      end
      4: begin
        // nine digits with a non-zero lead: the ninth overflows 32 bits
        send_word(hex_char($urandom_range(1, 15)), buffer_end());
        repeat (8) send_word(hex_char($urandom_range(15)), buffer_end());
      end
      default: begin
        // zero-size chunk, then a data byte: end of stream
        send_word(hex_char(0), buffer_end());
        send_word(CHAR_CR, buffer_end());
        send_word(CHAR_LF, buffer_end());
        send_word(8'($urandom), buffer_end());
      end
    endcase
    repeat (12) send_word(8'($urandom), buffer_end());

    // sticky status must survive a change of every register
    drain_and_settle();
    set_config(1'b0, 1'($urandom_range(1)), 24'($urandom_range(1, 8)));
    repeat (8) send_word(8'($urandom), buffer_end());
    drain_and_settle();

    if (fail_count == 0 && pending_words == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
